>>> rtl/tls_pkg.sv
// Package for the two-axis line stepper: field widths, operation and status codes.
// No dependencies; every other file of the block imports it.
package tls_pkg;

	// Field widths.
	localparam int unsigned COORD_W  = 12;
	localparam int unsigned CANVAS_W = 13;
	localparam int unsigned TICKS_W  = 13;
	localparam int unsigned TWICE_W  = 13;
	localparam int unsigned ERR_W    = 14;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned CFG_IDX_W = 1;

	// Largest coordinate range the stepper addresses.
	localparam int unsigned MAX_COORD = 4096;

	// Canvas size after reset.
	localparam logic [CANVAS_W-1:0] CANVAS_RESET = CANVAS_W'(256);

	// Operation codes of a request.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Status codes of a result.
	localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BUSY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_STEP     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_IDLE     = 3'd4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 1'b1;

endpackage

>>> rtl/tls_cmd_if.sv
// Request channel of the two-axis line stepper: valid/ready plus operation and target.
// Depends on tls_pkg.
interface tls_cmd_if;
	import tls_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [COORD_W-1:0] target_x;
	logic [COORD_W-1:0] target_y;

	modport source (output valid, operation, target_x, target_y, input ready);
	modport sink (input valid, operation, target_x, target_y, output ready);
endinterface

>>> rtl/tls_res_if.sv
// Result channel of the two-axis line stepper: valid/ready plus status and step pulses.
// Depends on tls_pkg.
interface tls_res_if;
	import tls_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                x_step;
	logic                y_step;
	logic                x_dir;
	logic                y_dir;
	logic                move_done;

	modport source (output valid, status, x_step, y_step, x_dir, y_dir, move_done,
		input ready);
	modport sink (input valid, status, x_step, y_step, x_dir, y_dir, move_done,
		output ready);
endinterface

>>> rtl/two_axis_line_stepper.sv
// Two-axis line stepper: top level with input register, DDA state and result register.
// Depends on tls_pkg, tls_cmd_if and tls_res_if.
//
// Each request gives exactly one result. A load request (operation 0) is answered
// busy while a move runs, out of range when the target is off the configured canvas,
// and otherwise accepted: the directions are set (Y inverted), the target becomes the
// position and a move of max(|dx|,|dy|) ticks is armed. Each tick request (operation 1)
// during a move reports the X and Y step pulses from exact integer error accumulators,
// and move_done on the last tick. The block takes one request every clock cycle while
// results are taken: a request waits in the input register, its single add-and-compare
// per axis is done on the way to the result register, and the result register is refilled
// as it is taken, so the rate is one request per cycle unless res.ready holds it off. Canvas
// registers may be written whenever the block is idle.
module two_axis_line_stepper (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tls_pkg::CANVAS_W-1:0]   cfg_data,
	tls_cmd_if.sink                        cmd,
	tls_res_if.source                      res
);
	import tls_pkg::*;

	// Configuration registers.
	logic [CANVAS_W-1:0] canvas_width_q;
	logic [CANVAS_W-1:0] canvas_height_q;

	// Move state.
	logic [COORD_W-1:0] position_x_q;
	logic [COORD_W-1:0] position_y_q;
	logic [TICKS_W-1:0] ticks_left_q;
	logic [ERR_W-1:0]   error_x_q;
	logic [ERR_W-1:0]   error_y_q;
	logic [TWICE_W-1:0] twice_delta_x_q;
	logic [TWICE_W-1:0] twice_delta_y_q;
	logic [TWICE_W-1:0] twice_major_q;
	logic               dir_x_q;
	logic               dir_y_q;

	// Input register stage.
	logic               valid_s1;
	logic               operation_s1;
	logic [COORD_W-1:0] target_x_s1;
	logic [COORD_W-1:0] target_y_s1;

	// Result register stage.
	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic                x_step_s2;
	logic                y_step_s2;
	logic                x_dir_s2;
	logic                y_dir_s2;
	logic                done_s2;

	// Handshake: the result register frees as it is taken, the input register as it moves.
	logic s2_free;
	logic s1_move;
	logic cmd_take;

	assign s2_free  = !valid_s2 || res.ready;
	assign s1_move  = valid_s1 && s2_free;
	assign cmd.ready = !valid_s1 || s2_free;
	assign cmd_take = cmd.valid && cmd.ready;

	// Load evaluation: range check, deltas and the major axis length.
	logic               busy;
	logic               off_canvas;
	logic [COORD_W-1:0] mag_x;
	logic [COORD_W-1:0] mag_y;
	logic [COORD_W-1:0] major;

	always_comb begin
		busy = (ticks_left_q != '0);
		off_canvas = ({1'b0, target_x_s1} >= canvas_width_q)
			|| ({1'b0, target_y_s1} >= canvas_height_q)
			|| ({1'b0, target_x_s1} >= CANVAS_W'(MAX_COORD))
			|| ({1'b0, target_y_s1} >= CANVAS_W'(MAX_COORD));
		mag_x = (target_x_s1 >= position_x_q) ? target_x_s1 - position_x_q
			: position_x_q - target_x_s1;
		mag_y = (target_y_s1 >= position_y_q) ? target_y_s1 - position_y_q
			: position_y_q - target_y_s1;
		major = (mag_x > mag_y) ? mag_x : mag_y;
	end

	// Tick evaluation: one add and one compare per axis.
	logic [ERR_W-1:0] sum_x;
	logic [ERR_W-1:0] sum_y;
	logic             step_x;
	logic             step_y;
	logic [ERR_W-1:0] next_err_x;
	logic [ERR_W-1:0] next_err_y;
	logic [TICKS_W-1:0] ticks_dec;

	always_comb begin
		sum_x = error_x_q + {1'b0, twice_delta_x_q};
		sum_y = error_y_q + {1'b0, twice_delta_y_q};
		step_x = (sum_x >= {1'b0, twice_major_q});
		step_y = (sum_y >= {1'b0, twice_major_q});
		next_err_x = step_x ? sum_x - {1'b0, twice_major_q} : sum_x;
		next_err_y = step_y ? sum_y - {1'b0, twice_major_q} : sum_y;
		ticks_dec = ticks_left_q - TICKS_W'(1);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_width_q  <= CANVAS_RESET;
			canvas_height_q <= CANVAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data;
				CFG_CANVAS_HEIGHT: canvas_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: control bit under reset, payload without.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			operation_s1 <= cmd.operation;
			target_x_s1  <= cmd.target_x;
			target_y_s1  <= cmd.target_y;
		end
	end

	// Move state update as a request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_x_q    <= '0;
			position_y_q    <= '0;
			ticks_left_q    <= '0;
			error_x_q       <= '0;
			error_y_q       <= '0;
			twice_delta_x_q <= '0;
			twice_delta_y_q <= '0;
			twice_major_q   <= '0;
			dir_x_q         <= 1'b0;
			dir_y_q         <= 1'b0;
		end else if (s1_move) begin
			if (operation_s1 == OP_LOAD) begin
				if (!busy && !off_canvas) begin
					position_x_q    <= target_x_s1;
					position_y_q    <= target_y_s1;
					ticks_left_q    <= {1'b0, major};
					error_x_q       <= {2'b00, major};
					error_y_q       <= {2'b00, major};
					twice_delta_x_q <= {mag_x, 1'b0};
					twice_delta_y_q <= {mag_y, 1'b0};
					twice_major_q   <= {major, 1'b0};
					dir_x_q         <= (target_x_s1 > position_x_q);
					dir_y_q         <= !(target_y_s1 > position_y_q);
				end
			end else if (busy) begin
				error_x_q    <= next_err_x;
				error_y_q    <= next_err_y;
				ticks_left_q <= ticks_dec;
			end
		end
	end

	// Result register: the directions shown are those after this request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			x_step_s2 <= 1'b0;
			y_step_s2 <= 1'b0;
			done_s2   <= 1'b0;
			x_dir_s2  <= dir_x_q;
			y_dir_s2  <= dir_y_q;
			if (operation_s1 == OP_LOAD) begin
				priority if (busy) begin
					status_s2 <= ST_BUSY;
				end else if (off_canvas) begin
					status_s2 <= ST_RANGE;
				end else begin
					status_s2 <= ST_ACCEPTED;
					x_dir_s2  <= (target_x_s1 > position_x_q);
					y_dir_s2  <= !(target_y_s1 > position_y_q);
				end
			end else if (busy) begin
				status_s2 <= ST_STEP;
				x_step_s2 <= step_x;
				y_step_s2 <= step_y;
				done_s2   <= (ticks_dec == '0);
			end else begin
				status_s2 <= ST_IDLE;
			end
		end
	end

	assign res.valid     = valid_s2;
	assign res.status    = status_s2;
	assign res.x_step    = x_step_s2;
	assign res.y_step    = y_step_s2;
	assign res.x_dir     = x_dir_s2;
	assign res.y_dir     = y_dir_s2;
	assign res.move_done = done_s2;

	// A running move always has a nonzero major length.
	a_move_has_major: assert property (@(posedge clk) disable iff (!arst_n)
		(ticks_left_q != '0) |-> (twice_major_q != '0))
		else $error("move running with zero major length");

	// Load results never carry step pulses or a move end.
	a_load_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (status_s2 == ST_ACCEPTED || status_s2 == ST_RANGE
			|| status_s2 == ST_BUSY)) |-> (!x_step_s2 && !y_step_s2 && !done_s2))
		else $error("load result with step pulse");

	// A tick during a move consumes exactly one tick.
	a_tick_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && operation_s1 == OP_TICK && busy)
			|=> (ticks_left_q == $past(ticks_dec)))
		else $error("tick did not count down the move");

endmodule

>>> verif/two_axis_line_stepper_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for two_axis_line_stepper: directed and random load/tick traffic,
// with a request-by-request line interpolation predictor and a scoreboard.
// Depends on tls_pkg, tls_cmd_if, tls_res_if and the two_axis_line_stepper RTL.
module two_axis_line_stepper_tb;
	import tls_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned PHASE_ITEMS = 110;

	// One result of the stepper as the scoreboard holds it.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                x_step;
		logic                y_step;
		logic                x_dir;
		logic                y_dir;
		logic                move_done;
	} step_res_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CANVAS_W-1:0]  cfg_data;

	tls_cmd_if cmd_ch ();
	tls_res_if res_ch ();

	two_axis_line_stepper u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// Predicted block state and canvas registers.
	logic [COORD_W-1:0]  cur_x, cur_y;
	logic [TICKS_W-1:0]  ticks_rem;
	logic [ERR_W-1:0]    acc_x, acc_y;
	logic [TWICE_W-1:0]  inc_x, inc_y, span2;
	logic                dir_x, dir_y;
	logic [CANVAS_W-1:0] canvas_w, canvas_h;

	// Expected results, oldest first, and run bookkeeping.
	step_res_t   expected_steps[$];
	int unsigned fail_count = 0;
	int unsigned requests_sent = 0;
	int unsigned cycles = 0;
	int unsigned hold_req_cycles = 0;
	int unsigned burst_left = 10;
	bit          no_gaps = 1'b0;
	bit          cmd_offered = 1'b0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// One axis of the error accumulator: returns {step, new accumulator}.
	function automatic logic [ERR_W:0] axis_advance(input logic [ERR_W-1:0] acc,
		input logic [TWICE_W-1:0] inc);
		logic [ERR_W-1:0] sum;
		sum = acc + ERR_W'(inc);
		if (sum >= ERR_W'(span2)) begin
			return {1'b1, sum - ERR_W'(span2)};
		end
		return {1'b0, sum};
	endfunction

	// Works out the result of one accepted request and advances the predicted state.
	function automatic step_res_t predict_step(input logic op, input logic [COORD_W-1:0] tx,
		input logic [COORD_W-1:0] ty);
		step_res_t          r;
		logic [COORD_W-1:0] mx, my, n;
		logic [ERR_W:0]     ax, ay;
		r = '0;
		if (op == OP_LOAD) begin
			if (ticks_rem != 0) begin
				r.status = ST_BUSY;
			end else if (tx >= canvas_w || ty >= canvas_h || tx >= MAX_COORD ||
				ty >= MAX_COORD) begin
				r.status = ST_RANGE;
			end else begin
				mx = (tx > cur_x) ? tx - cur_x : cur_x - tx;
				my = (ty > cur_y) ? ty - cur_y : cur_y - ty;
				n = (mx > my) ? mx : my;
				dir_x = (tx > cur_x);
				dir_y = !(ty > cur_y);
				ticks_rem = TICKS_W'(n);
				inc_x = {mx, 1'b0};
				inc_y = {my, 1'b0};
				span2 = {n, 1'b0};
				acc_x = ERR_W'(n);
				acc_y = ERR_W'(n);
				cur_x = tx;
				cur_y = ty;
				r.status = ST_ACCEPTED;
			end
		end else if (ticks_rem == 0) begin
			r.status = ST_IDLE;
		end else begin
			ax = axis_advance(acc_x, inc_x);
			ay = axis_advance(acc_y, inc_y);
			acc_x = ax[ERR_W-1:0];
			acc_y = ay[ERR_W-1:0];
			r.x_step = ax[ERR_W];
			r.y_step = ay[ERR_W];
			ticks_rem = ticks_rem - 1'b1;
			r.move_done = (ticks_rem == 0);
			r.status = ST_STEP;
		end
		r.x_dir = dir_x;
		r.y_dir = dir_y;
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Scoreboard: every accepted result is matched against the oldest expectation.
	initial begin
		step_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
				if (expected_steps.size() == 0) begin
					$error("unexpected result: status %0d", res_ch.status);
					fail_count++;
				end else begin
					want = expected_steps.pop_front();
					check_field("status", want.status, res_ch.status);
					check_field("x_step", want.x_step, res_ch.x_step);
					check_field("y_step", want.y_step, res_ch.y_step);
					check_field("x_dir", want.x_dir, res_ch.x_dir);
					check_field("y_dir", want.y_dir, res_ch.y_dir);
					check_field("move_done", want.move_done, res_ch.move_done);
				end
			end
		end
	end

	// Result ready: random segments of ready and stall, long clean stretches, and a
	// long hold-off on request.
	initial begin
		int unsigned seg_left;
		int unsigned hold_left;
		bit          seg_ready;
		seg_left = 0;
		hold_left = 0;
		seg_ready = 1'b1;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req_cycles > 0) begin
				hold_left = hold_req_cycles;
				hold_req_cycles = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					case ($urandom_range(0, 9))
						0, 1: begin
							seg_ready = 1'b1;
							seg_left = $urandom_range(30, 80);
						end
						2, 3, 4, 5: begin
							seg_ready = 1'b1;
							seg_left = $urandom_range(1, 8);
						end
						default: begin
							seg_ready = 1'b0;
							seg_left = $urandom_range(1, 6);
						end
					endcase
				end
				seg_left--;
				res_ch.ready <= seg_ready;
			end
		end
	end

	// Offers one request, waits for it to be taken, records its expected result and
	// then keeps up the burst pacing.
	task automatic send_request(input logic op, input logic [COORD_W-1:0] tx,
		input logic [COORD_W-1:0] ty);
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.target_x <= tx;
		cmd_ch.target_y <= ty;
		cmd_offered = 1'b1;
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		expected_steps.push_back(predict_step(op, tx, ty));
		requests_sent++;
		if (!no_gaps) begin
			if (burst_left > 0) burst_left--;
			if (burst_left == 0) begin
				cmd_ch.valid <= 1'b0;
				cmd_offered = 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Stops offering and waits until every expected result has come back.
	task automatic drain();
		if (cmd_offered) begin
			cmd_ch.valid <= 1'b0;
			cmd_offered = 1'b0;
		end
		while (expected_steps.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both canvas registers on consecutive edges.
	task automatic write_canvas(input logic [CANVAS_W-1:0] w, input logic [CANVAS_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		canvas_w = w;
		cfg_index <= CFG_CANVAS_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		canvas_h = h;
		cfg_we <= 1'b0;
	endtask

	task automatic finish_move();
		while (ticks_rem != 0) begin
			send_request(OP_TICK, COORD_W'($urandom_range(0, 4095)),
				COORD_W'($urandom_range(0, 4095)));
		end
	endtask

	// Idle ticks, a load to the current point and loads off the default canvas.
	task automatic test_idle_and_range();
		send_request(OP_TICK, '0, '0);
		send_request(OP_LOAD, '0, '0);
		send_request(OP_TICK, 12'hFFF, 12'hFFF);
		send_request(OP_LOAD, 12'd256, 12'd0);
		send_request(OP_LOAD, 12'd0, 12'd256);
		send_request(OP_LOAD, 12'hFFF, 12'hFFF);
		send_request(OP_LOAD, 12'd255, 12'hFFF);
	endtask

	// Short moves in several directions, a busy load, and a zero-length move.
	task automatic test_short_moves();
		send_request(OP_LOAD, 12'd3, 12'd1);
		send_request(OP_LOAD, 12'd5, 12'd5);
		finish_move();
		send_request(OP_TICK, '0, '0);
		send_request(OP_LOAD, 12'd1, 12'd4);
		finish_move();
		send_request(OP_LOAD, 12'd1, 12'd2);
		finish_move();
		send_request(OP_LOAD, 12'd1, 12'd2);
		send_request(OP_TICK, '0, '0);
	endtask

	// Canvas sizes at and beyond the extremes, a long move, and a canvas change in
	// the middle of a move.
	task automatic test_canvas_extremes();
		drain();
		write_canvas(13'd0, 13'd0);
		send_request(OP_LOAD, 12'd0, 12'd0);
		send_request(OP_LOAD, 12'd1, 12'd2);
		drain();
		write_canvas(13'd1, 13'd1);
		send_request(OP_LOAD, 12'd0, 12'd0);
		finish_move();
		send_request(OP_LOAD, 12'd1, 12'd0);
		send_request(OP_LOAD, 12'd0, 12'd1);
		drain();
		write_canvas(13'd8191, 13'd8191);
		send_request(OP_LOAD, 12'd320, 12'd97);
		for (int i = 0; i < 100; i++) begin
			send_request(OP_TICK, '0, '0);
		end
		// The running move must not notice the smaller canvas.
		drain();
		write_canvas(13'd1, 13'd1);
		send_request(OP_LOAD, 12'd0, 12'd0);
		finish_move();
		send_request(OP_LOAD, 12'hFFF, 12'hFFF);
		drain();
		write_canvas(13'd4096, 13'd4096);
		send_request(OP_LOAD, 12'd330, 12'd90);
		send_request(OP_LOAD, 12'hFFF, 12'hFFF);
		finish_move();
	endtask

	// The receiver holds off while requests keep coming, so the block fills and stalls.
	task automatic test_backpressure();
		drain();
		no_gaps = 1'b1;
		hold_req_cycles = 150;
		send_request(OP_LOAD, 12'd360, 12'd70);
		finish_move();
		send_request(OP_TICK, '0, '0);
		no_gaps = 1'b0;
		drain();
	endtask

	// Random traffic over several canvas settings: mostly loads near the current point
	// followed by their ticks, mixed with random loads, busy loads and idle ticks.
	task automatic test_random_traffic();
		int unsigned phase_w[9] = '{16, 1, 4096, 256, 64, 8191, 0, 2, 4096};
		int unsigned phase_h[9] = '{16, 4096, 1, 256, 8191, 8191, 0, 2, 4096};
		int unsigned w, h, start, r, lim_x, lim_y, span;
		int          nx, ny;
		for (int p = 0; p < 9; p++) begin
			drain();
			w = phase_w[p];
			h = phase_h[p];
			if (w == 0) begin
				w = $urandom_range(1, 600);
				h = $urandom_range(1, 600);
			end
			write_canvas(CANVAS_W'(w), CANVAS_W'(h));
			lim_x = (w > MAX_COORD) ? MAX_COORD - 1 : w - 1;
			lim_y = (h > MAX_COORD) ? MAX_COORD - 1 : h - 1;
			start = requests_sent;
			while (requests_sent - start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (ticks_rem == 0 && r < 70) begin
					// Well-formed load to a point near the current one.
					span = ($urandom_range(0, 9) == 0) ? 300 : 16;
					nx = int'(cur_x) + int'($urandom_range(0, 2 * span)) - int'(span);
					ny = int'(cur_y) + int'($urandom_range(0, 2 * span)) - int'(span);
					if (nx < 0) nx = 0;
					if (nx > int'(lim_x)) nx = lim_x;
					if (ny < 0) ny = 0;
					if (ny > int'(lim_y)) ny = lim_y;
					send_request(OP_LOAD, COORD_W'(nx), COORD_W'(ny));
				end else if ((ticks_rem == 0 && r < 85) || (ticks_rem != 0 && r >= 90)) begin
					send_request(OP_LOAD, COORD_W'($urandom_range(0, 4095)),
						COORD_W'($urandom_range(0, 4095)));
				end else begin
					send_request(OP_TICK, COORD_W'($urandom_range(0, 4095)),
						COORD_W'($urandom_range(0, 4095)));
				end
			end
		end
	endtask

	// Test sequence.
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CANVAS_WIDTH;
		cfg_data <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_LOAD;
		cmd_ch.target_x <= '0;
		cmd_ch.target_y <= '0;
		cur_x = '0;
		cur_y = '0;
		ticks_rem = '0;
		acc_x = '0;
		acc_y = '0;
		inc_x = '0;
		inc_y = '0;
		span2 = '0;
		dir_x = 1'b0;
		dir_y = 1'b0;
		canvas_w = CANVAS_RESET;
		canvas_h = CANVAS_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_and_range();
		test_short_moves();
		test_canvas_extremes();
		test_backpressure();
		test_random_traffic();
		drain();
		repeat (8) @(posedge clk);

		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
